>>> rtl/pmq_pkg.sv
`timescale 1ns / 1ps

package pmq_pkg;

  localparam int STORE_DEPTH     = 16;
  localparam int ADDR_W          = 4;
  localparam int CNT_W           = 5;
  localparam int DEF_QUEUE_LIMIT = 15;

  localparam logic [3:0] ACT_ENQ_NEW  = 4'd0;
  localparam logic [3:0] ACT_ENQ_OLD  = 4'd1;
  localparam logic [3:0] ACT_DEQ      = 4'd2;
  localparam logic [3:0] ACT_REM_KEY  = 4'd3;
  localparam logic [3:0] ACT_REM_PRIO = 4'd4;
  localparam logic [3:0] ACT_PUSH     = 4'd5;
  localparam logic [3:0] ACT_POP      = 4'd6;
  localparam logic [3:0] ACT_INS_AT   = 4'd7;
  localparam logic [3:0] ACT_REM_AT   = 4'd8;

  localparam logic REG_EVICT_FIRST  = 1'b0;
  localparam logic REG_EVICT_SECOND = 1'b1;

  typedef struct packed {
    logic [3:0]  action;
    logic [15:0] msg_key;
    logic [15:0] msg_priority;
    logic [31:0] msg_payload;
    logic [15:0] window_min;
    logic [15:0] window_max;
    logic [4:0]  position;
  } pmq_req_t;

  typedef struct packed {
    logic        ok;
    logic [15:0] out_key;
    logic [15:0] out_priority;
    logic [31:0] out_payload;
    logic        evicted;
    logic [4:0]  entry_count;
    logic        is_empty;
  } pmq_rsp_t;

  typedef struct packed {
    logic [15:0] key;
    logic [15:0] prio;
    logic [31:0] payload;
  } pmq_entry_t;

endpackage

>>> rtl/pmq_mem.sv
`timescale 1ns / 1ps

module pmq_mem import pmq_pkg::*; (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  pmq_entry_t        wdata,
  input  logic [ADDR_W-1:0] raddr,
  output pmq_entry_t        rdata
);

  pmq_entry_t mem [STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/pmq_cmp.sv
`timescale 1ns / 1ps

module pmq_cmp import pmq_pkg::*; (
  input  logic        key_mode,
  input  pmq_entry_t  entry,
  input  logic [15:0] key,
  input  logic [15:0] lo,
  input  logic [15:0] hi,
  input  logic        want_large,
  input  logic        found,
  input  logic [15:0] best,
  output logic        hit
);

  logic in_win;
  logic better;

  always_comb begin
    in_win = (entry.prio >= lo) && (entry.prio <= hi);
    // ties go to the later (older) entry
    better = want_large ? (entry.prio >= best) : (entry.prio <= best);
    if (key_mode) begin
      hit = !found && (entry.key == key);
    end else begin
      hit = in_win && (!found || better);
    end
  end

endmodule

>>> rtl/pmq_ctrl.sv
`timescale 1ns / 1ps

module pmq_ctrl import pmq_pkg::*; #(
  parameter int QUEUE_LIMIT = DEF_QUEUE_LIMIT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  pmq_req_t          req,
  input  logic [15:0]       evict_first_bound,
  input  logic [15:0]       evict_second_bound,
  input  logic              take,
  output logic              idle,
  output logic              done,
  output pmq_rsp_t          result,
  output logic              mem_we,
  output logic [ADDR_W-1:0] mem_waddr,
  output pmq_entry_t        mem_wdata,
  output logic [ADDR_W-1:0] mem_raddr,
  input  pmq_entry_t        mem_rdata
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_SEARCH  = 3'd1;
  localparam logic [2:0] S_REMOVE  = 3'd2;
  localparam logic [2:0] S_INS_CHK = 3'd3;
  localparam logic [2:0] S_INSERT  = 3'd4;
  localparam logic [2:0] S_DONE    = 3'd5;

  logic [2:0]        state;
  pmq_req_t          r;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  cur;
  logic [CNT_W-1:0]  cur_m1;
  logic              rvalid;
  logic [ADDR_W-1:0] raddr_q;
  logic              found;
  logic [15:0]       best;
  logic [ADDR_W-1:0] idx;
  logic [CNT_W-1:0]  ins_pos;
  pmq_entry_t        got;
  logic              ok;
  logic              removed;
  logic              ev;
  logic              evict_mode;
  logic              key_mode;
  logic [15:0]       lo;
  logic [15:0]       hi;
  logic              want_large;

  logic              issue;
  logic              hit;
  logic [CNT_W-1:0]  ipos;
  logic [CNT_W-1:0]  rem_at_pos;
  logic [15:0]       win_a;
  logic [15:0]       win_b;
  pmq_entry_t        new_entry;

  function automatic logic [ADDR_W-1:0] cur_of(input logic [CNT_W-1:0] v);
    return v[ADDR_W-1:0];
  endfunction

  assign cur_m1 = cur - CNT_W'(1);
  assign new_entry = '{key: r.msg_key, prio: r.msg_priority, payload: r.msg_payload};

  pmq_cmp u_cmp (
    .key_mode   (key_mode),
    .entry      (mem_rdata),
    .key        (r.msg_key),
    .lo         (lo),
    .hi         (hi),
    .want_large (want_large),
    .found      (found),
    .best       (best),
    .hit        (hit)
  );

  // memory sweep: a moved entry is written the cycle after its read
  always_comb begin
    issue     = 1'b0;
    mem_raddr = cur[ADDR_W-1:0];
    mem_we    = 1'b0;
    mem_waddr = raddr_q;
    mem_wdata = mem_rdata;
    unique case (state)
      S_SEARCH: begin
        issue = cur < count;
      end
      S_REMOVE: begin
        issue = cur < count;
        if (rvalid && raddr_q != idx) begin
          mem_we    = 1'b1;
          mem_waddr = raddr_q - ADDR_W'(1);
        end
      end
      S_INSERT: begin
        issue     = cur > ins_pos;
        mem_raddr = cur_m1[ADDR_W-1:0];
        if (rvalid) begin
          mem_we    = 1'b1;
          mem_waddr = raddr_q + ADDR_W'(1);
        end else if (!issue) begin
          mem_we    = 1'b1;
          mem_waddr = ins_pos[ADDR_W-1:0];
          mem_wdata = new_entry;
        end
      end
      default: begin
        issue = 1'b0;
      end
    endcase
  end

  always_comb begin
    case (r.action) inside
      ACT_ENQ_OLD: ipos = (int'(count) < QUEUE_LIMIT) ? count : '0;
      ACT_INS_AT:  ipos = r.position;
      default:     ipos = '0;
    endcase
    rem_at_pos = (req.position == '0) ? '0 : req.position - CNT_W'(1);
    win_a = (req.action == ACT_REM_PRIO) ? req.window_min : evict_first_bound;
    win_b = (req.action == ACT_REM_PRIO) ? req.window_max : evict_second_bound;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      rvalid <= 1'b0;
    end else begin
      rvalid <= issue;
      if (issue) begin
        raddr_q <= mem_raddr;
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            r          <= req;
            ok         <= 1'b0;
            removed    <= 1'b0;
            ev         <= 1'b0;
            found      <= 1'b0;
            best       <= '0;
            cur        <= '0;
            evict_mode <= 1'b0;
            key_mode   <= (req.action == ACT_REM_KEY);
            want_large <= win_b > win_a;
            lo         <= (win_b > win_a) ? win_a : win_b;
            hi         <= (win_b > win_a) ? win_b : win_a;
            unique case (req.action) inside
              ACT_ENQ_NEW, ACT_ENQ_OLD: begin
                if (int'(count) > QUEUE_LIMIT) begin
                  evict_mode <= 1'b1;
                  state      <= S_SEARCH;
                end else begin
                  state <= S_INS_CHK;
                end
              end
              ACT_DEQ: begin
                if (count != '0) begin
                  idx   <= cur_of(count - CNT_W'(1));
                  cur   <= count - CNT_W'(1);
                  state <= S_REMOVE;
                end else begin
                  state <= S_DONE;
                end
              end
              ACT_REM_KEY, ACT_REM_PRIO: begin
                state <= (count != '0) ? S_SEARCH : S_DONE;
              end
              ACT_PUSH, ACT_INS_AT: begin
                state <= S_INS_CHK;
              end
              ACT_POP: begin
                if (count != '0) begin
                  idx   <= '0;
                  state <= S_REMOVE;
                end else begin
                  state <= S_DONE;
                end
              end
              ACT_REM_AT: begin
                if (rem_at_pos < count) begin
                  idx   <= rem_at_pos[ADDR_W-1:0];
                  cur   <= rem_at_pos;
                  state <= S_REMOVE;
                end else begin
                  state <= S_DONE;
                end
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_SEARCH: begin
          if (issue) begin
            cur <= cur + CNT_W'(1);
          end
          if (rvalid && hit) begin
            found <= 1'b1;
            best  <= mem_rdata.prio;
            idx   <= raddr_q;
          end
          if (!issue && !rvalid) begin
            if (found) begin
              cur   <= {1'b0, idx};
              state <= S_REMOVE;
            end else if (evict_mode) begin
              state <= S_INS_CHK;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_REMOVE: begin
          if (issue) begin
            cur <= cur + CNT_W'(1);
          end
          if (rvalid && raddr_q == idx) begin
            got <= mem_rdata;
          end
          if (!issue && !rvalid) begin
            count <= count - CNT_W'(1);
            if (evict_mode) begin
              ev    <= 1'b1;
              state <= S_INS_CHK;
            end else begin
              ok      <= 1'b1;
              removed <= 1'b1;
              state   <= S_DONE;
            end
          end
        end
        S_INS_CHK: begin
          if (count == CNT_W'(STORE_DEPTH) || ipos > count) begin
            state <= S_DONE;
          end else begin
            ins_pos <= ipos;
            cur     <= count;
            state   <= S_INSERT;
          end
        end
        S_INSERT: begin
          if (issue) begin
            cur <= cur_m1;
          end
          if (!issue && !rvalid) begin
            count <= count + CNT_W'(1);
            ok    <= 1'b1;
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (take) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    result.ok           = ok;
    result.out_key      = removed ? got.key : '0;
    result.out_priority = removed ? got.prio : '0;
    result.out_payload  = removed ? got.payload : '0;
    result.evicted      = ev;
    result.entry_count  = count;
    result.is_empty     = (count == '0);
  end

  assign idle = (state == S_IDLE);
  assign done = (state == S_DONE);

endmodule

>>> rtl/priority_message_queue.sv
`timescale 1ns / 1ps
// each memory sweep reads one entry per cycle; the longest request is an enqueue on a
// full store
// requests: a new request is taken only once the previous one is done; a result may
// wait in the result register while the next request is taken
// reset: held count, sequencer and result valid cleared, eviction bounds 0 and 65535;
// message memory is not cleared and holds no valid data until written

module priority_message_queue import pmq_pkg::*; #(
  parameter int QUEUE_LIMIT = DEF_QUEUE_LIMIT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  pmq_req_t    req,
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output pmq_rsp_t    rsp,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  logic              start;
  logic              take;
  logic              idle;
  logic              done;
  pmq_rsp_t          result;
  logic [15:0]       evict_first_bound;
  logic [15:0]       evict_second_bound;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  pmq_entry_t        mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;
  pmq_entry_t        mem_rdata;

  assign req_ready = idle;
  assign start     = req_valid && req_ready;
  // result register frees the sequencer while the response waits
  assign take      = done && (!rsp_valid || rsp_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      evict_first_bound  <= '0;
      evict_second_bound <= 16'hFFFF;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_EVICT_FIRST:  evict_first_bound  <= cfg_data;
        REG_EVICT_SECOND: evict_second_bound <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (take) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      rsp <= result;
    end
  end

  pmq_ctrl #(
    .QUEUE_LIMIT (QUEUE_LIMIT)
  ) u_ctrl (
    .clk                (clk),
    .rst                (rst),
    .start              (start),
    .req                (req),
    .evict_first_bound  (evict_first_bound),
    .evict_second_bound (evict_second_bound),
    .take               (take),
    .idle               (idle),
    .done               (done),
    .result             (result),
    .mem_we             (mem_we),
    .mem_waddr          (mem_waddr),
    .mem_wdata          (mem_wdata),
    .mem_raddr          (mem_raddr),
    .mem_rdata          (mem_rdata)
  );

  pmq_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

>>> rtl/pmq_check.sv
`timescale 1ns / 1ps

module pmq_check import pmq_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     req_valid,
  input logic     req_ready,
  input logic     rsp_valid,
  input logic     rsp_ready,
  input pmq_rsp_t rsp
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("response changed while stalled");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.is_empty == (rsp.entry_count == 5'd0)) &&
                  (rsp.entry_count <= 5'd16))
    else $error("entry count and empty flag disagree");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.ok |-> rsp.out_key == '0 && rsp.out_priority == '0 &&
                             rsp.out_payload == '0)
    else $error("failed request returned message data");

  a_evict_no_data: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.evicted |-> rsp.out_key == '0 && rsp.out_priority == '0 &&
                                 rsp.out_payload == '0 && rsp.entry_count != 5'd0)
    else $error("eviction returned message data");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while previous one still in work");

endmodule

bind priority_message_queue pmq_check u_pmq_check (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);

>>> bench/priority_message_queue_tb.sv
`timescale 1ns / 1ps

module priority_message_queue_tb;
  import pmq_pkg::*;

  localparam int LIMIT         = DEF_QUEUE_LIMIT;
  localparam int SETTLE_CYCLES = 64;
  localparam int MAX_REPORTS   = 10;
  localparam int LONG_HOLD     = 400;
  localparam int NUM_PHASES    = 7;

  localparam logic [3:0] ACT_NONE_FIRST = 4'd9;
  localparam logic [3:0] ACT_NONE_LAST  = 4'd15;

  typedef struct {
    pmq_req_t req;
    bit       typed;
    pmq_rsp_t rsp;
  } directed_row_t;

  typedef struct {
    int first_bound;
    int second_bound;
    int insert_pct;
    int idle_pct;
    int items;
  } phase_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_ready;
  pmq_req_t    req = '0;
  logic        rsp_valid;
  logic        rsp_ready = 1'b0;
  pmq_rsp_t    rsp;
  logic        cfg_we = 1'b0;
  logic        cfg_index = REG_EVICT_FIRST;
  logic [15:0] cfg_data = '0;

  // shadow copy of the queue
  pmq_entry_t  model_store [STORE_DEPTH];
  int          model_count = 0;
  logic [15:0] evict_bound_a = 16'h0000;
  logic [15:0] evict_bound_b = 16'hffff;

  pmq_rsp_t    pending_rsp [$];
  pmq_rsp_t    want_rsp;
  int          rsp_count = 0;
  int          mismatch_count = 0;

  int          sender_idle_pct = 30;
  int          rsp_idle_pct = 30;
  int          hold_left = 0;
  bit          long_hold_done = 1'b0;

  logic [3:0]  insert_ops [4] = '{ACT_ENQ_NEW, ACT_ENQ_OLD, ACT_PUSH, ACT_INS_AT};
  logic [3:0]  remove_ops [5] = '{ACT_DEQ, ACT_REM_KEY, ACT_REM_PRIO, ACT_POP, ACT_REM_AT};

  directed_row_t directed_rows [$];
  phase_t        phases [NUM_PHASES] = '{
    '{0,     65535, 80, 30, 110},
    '{65535, 0,     65, 30, 100},
    '{100,   200,   70, 0,  80},
    '{300,   100,   60, 40, 80},
    '{0,     0,     75, 30, 70},
    '{65535, 65535, 75, 30, 60},
    '{-1,    -1,    55, 30, 100}
  };

  priority_message_queue #(.QUEUE_LIMIT(LIMIT)) i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic bit insert_entry(int pos, pmq_entry_t e);
    if (model_count >= STORE_DEPTH || pos > model_count) return 1'b0;
    for (int i = model_count; i > pos; i--) model_store[i] = model_store[i - 1];
    model_store[pos] = e;
    model_count++;
    return 1'b1;
  endfunction

  function automatic bit extract_entry(int pos, output pmq_entry_t e);
    e = '0;
    if (pos >= model_count) return 1'b0;
    e = model_store[pos];
    for (int i = pos; i + 1 < model_count; i++) model_store[i] = model_store[i + 1];
    model_count--;
    return 1'b1;
  endfunction

  // largest priority in window when b > a, else smallest; ties to the older entry
  function automatic int pick_window(logic [15:0] a, logic [15:0] b);
    int          found;
    logic [15:0] best;
    logic [15:0] lo;
    logic [15:0] hi;
    logic [15:0] p;
    bit          want_large;
    found = -1;
    best = '0;
    want_large = b > a;
    lo = want_large ? a : b;
    hi = want_large ? b : a;
    for (int i = 0; i < model_count; i++) begin
      p = model_store[i].prio;
      if (p >= lo && p <= hi &&
          (found < 0 || (want_large ? p >= best : p <= best))) begin
        best = p;
        found = i;
      end
    end
    return found;
  endfunction

  function automatic bit evict_on_overflow();
    int         idx;
    pmq_entry_t dropped;
    if (model_count <= LIMIT) return 1'b0;
    idx = pick_window(evict_bound_a, evict_bound_b);
    if (idx < 0) return 1'b0;
    return extract_entry(idx, dropped);
  endfunction

  function automatic pmq_rsp_t predict_response(pmq_req_t r);
    pmq_rsp_t   res;
    pmq_entry_t fresh;
    pmq_entry_t got;
    bit         ok;
    bit         ev;
    int         idx;
    fresh = {r.msg_key, r.msg_priority, r.msg_payload};
    got = '0;
    ok = 1'b0;
    ev = 1'b0;
    idx = -1;
    case (r.action)
      ACT_ENQ_NEW: begin
        ev = evict_on_overflow();
        ok = insert_entry(0, fresh);
      end
      ACT_ENQ_OLD: begin
        ev = evict_on_overflow();
        ok = insert_entry(model_count < LIMIT ? model_count : 0, fresh);
      end
      ACT_DEQ: begin
        if (model_count > 0) ok = extract_entry(model_count - 1, got);
      end
      ACT_REM_KEY: begin
        // newest match wins
        for (int i = model_count - 1; i >= 0; i--)
          if (model_store[i].key == r.msg_key) idx = i;
        if (idx >= 0) ok = extract_entry(idx, got);
      end
      ACT_REM_PRIO: begin
        idx = pick_window(r.window_min, r.window_max);
        if (idx >= 0) ok = extract_entry(idx, got);
      end
      ACT_PUSH:   ok = insert_entry(0, fresh);
      ACT_POP:    ok = extract_entry(0, got);
      ACT_INS_AT: ok = insert_entry(int'(r.position), fresh);
      ACT_REM_AT: ok = extract_entry(r.position == 0 ? 0 : int'(r.position) - 1, got);
      default: ;
    endcase
    res.ok           = ok;
    res.out_key      = got.key;
    res.out_priority = got.prio;
    res.out_payload  = got.payload;
    res.evicted      = ev;
    res.entry_count  = 5'(model_count);
    res.is_empty     = (model_count == 0);
    return res;
  endfunction

  function automatic pmq_req_t mk_req(logic [3:0] act, logic [15:0] key, logic [15:0] prio,
                                      logic [31:0] payload, logic [15:0] wmin,
                                      logic [15:0] wmax, logic [4:0] pos);
    pmq_req_t r;
    r.action       = act;
    r.msg_key      = key;
    r.msg_priority = prio;
    r.msg_payload  = payload;
    r.window_min   = wmin;
    r.window_max   = wmax;
    r.position     = pos;
    return r;
  endfunction

  function automatic pmq_rsp_t mk_rsp(bit ok, logic [15:0] key, logic [15:0] prio,
                                      logic [31:0] payload, logic [4:0] count);
    pmq_rsp_t r;
    r.ok           = ok;
    r.out_key      = key;
    r.out_priority = prio;
    r.out_payload  = payload;
    r.evicted      = 1'b0;
    r.entry_count  = count;
    r.is_empty     = (count == 0);
    return r;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int pick_gap(int pct);
    if ($urandom_range(0, 99) >= pct) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 60);
    return $urandom_range(1, 4);
  endfunction

  // priorities clustered around the eviction windows used below
  function automatic logic [15:0] random_priority();
    case ($urandom_range(0, 3))
      0:       return 16'($urandom());
      1:       return 16'($urandom_range(0, 15) * 20);
      2:       return $urandom_range(0, 1) ? 16'hffff : 16'h0000;
      default: return 16'($urandom_range(90, 310));
    endcase
  endfunction

  function automatic pmq_req_t random_request(int insert_pct);
    pmq_req_t r;
    if ($urandom_range(0, 99) < 4)
      r.action = 4'($urandom_range(ACT_NONE_FIRST, ACT_NONE_LAST));
    else if ($urandom_range(0, 99) < insert_pct)
      r.action = insert_ops[$urandom_range(0, 3)];
    else
      r.action = remove_ops[$urandom_range(0, 4)];
    r.msg_key      = ($urandom_range(0, 3) != 0) ? 16'($urandom_range(0, 7)) : 16'($urandom());
    r.msg_priority = random_priority();
    r.msg_payload  = $urandom();
    case ($urandom_range(0, 3))
      0, 1: begin
        r.window_min = random_priority();
        r.window_max = random_priority();
      end
      2: begin
        r.window_min = 16'($urandom());
        r.window_max = 16'($urandom());
      end
      default: begin
        r.window_min = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
        r.window_max = ~r.window_min;
      end
    endcase
    r.position = ($urandom_range(0, 4) != 0) ? 5'($urandom_range(0, model_count + 1))
                                             : 5'($urandom_range(0, 31));
    return r;
  endfunction

  task automatic send_request(pmq_req_t item, bit typed, pmq_rsp_t typed_rsp);
    int       gap;
    pmq_rsp_t predicted;
    gap = pick_gap(sender_idle_pct);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req       <= item;
    req_valid <= 1'b1;
    do begin
      @(posedge clk);
    end while (!req_ready);
    predicted = predict_response(item);
    pending_rsp.push_back(typed ? typed_rsp : predicted);
    @(negedge clk);
  endtask

  // block is idle once every response is back and the last sweep has had time to end
  task automatic settle_idle();
    req_valid <= 1'b0;
    while (pending_rsp.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_window(logic [15:0] a, logic [15:0] b);
    cfg_we    <= 1'b1;
    cfg_index <= REG_EVICT_FIRST;
    cfg_data  <= a;
    @(negedge clk);
    cfg_index <= REG_EVICT_SECOND;
    cfg_data  <= b;
    @(negedge clk);
    cfg_we    <= 1'b0;
    evict_bound_a = a;
    evict_bound_b = b;
  endtask

  initial begin
    wait (!rst);
    @(negedge clk);
    forever begin
      if (hold_left > 0) begin
        rsp_ready <= 1'b0;
        hold_left--;
      end else if (!long_hold_done && rsp_count >= 60) begin
        // long back-pressure so the queue stalls its request side
        long_hold_done = 1'b1;
        hold_left = LONG_HOLD - 1;
        rsp_ready <= 1'b0;
      end else begin
        hold_left = pick_gap(rsp_idle_pct);
        rsp_ready <= (hold_left == 0);
      end
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      rsp_count++;
      if (pending_rsp.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("response %0d with no request outstanding: ok=%0d key=%h count=%0d",
                   rsp_count, rsp.ok, rsp.out_key, rsp.entry_count);
      end else begin
        want_rsp = pending_rsp.pop_front();
        if (rsp.ok !== want_rsp.ok || rsp.out_key !== want_rsp.out_key ||
            rsp.out_priority !== want_rsp.out_priority ||
            rsp.out_payload !== want_rsp.out_payload || rsp.evicted !== want_rsp.evicted ||
            rsp.entry_count !== want_rsp.entry_count || rsp.is_empty !== want_rsp.is_empty) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("response %0d expected ok=%0d key=%h prio=%h payload=%h ev=%0d cnt=%0d e=%0d",
                     rsp_count, want_rsp.ok, want_rsp.out_key, want_rsp.out_priority,
                     want_rsp.out_payload, want_rsp.evicted, want_rsp.entry_count,
                     want_rsp.is_empty);
            $display("response %0d actual   ok=%0d key=%h prio=%h payload=%h ev=%0d cnt=%0d e=%0d",
                     rsp_count, rsp.ok, rsp.out_key, rsp.out_priority, rsp.out_payload,
                     rsp.evicted, rsp.entry_count, rsp.is_empty);
          end
        end
      end
    end
  end

  initial begin
    #3_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    directed_rows = '{
      // empty queue right after reset
      '{mk_req(ACT_DEQ, 0, 0, 0, 0, 0, 0), 1'b1, mk_rsp(0, 0, 0, 0, 0)},
      '{mk_req(ACT_POP, 16'hffff, 16'hffff, '1, 0, 0, 0), 1'b1, mk_rsp(0, 0, 0, 0, 0)},
      '{mk_req(ACT_REM_AT, 0, 0, 0, 0, 0, 5'd0), 1'b1, mk_rsp(0, 0, 0, 0, 0)},
      '{mk_req(ACT_REM_PRIO, 0, 0, 0, 16'h0000, 16'hffff, 0), 1'b1, mk_rsp(0, 0, 0, 0, 0)},
      '{mk_req(ACT_REM_KEY, 16'h0000, 0, 0, 0, 0, 0), 1'b1, mk_rsp(0, 0, 0, 0, 0)},
      '{mk_req(ACT_INS_AT, 1, 1, 1, 0, 0, 5'd1), 1'b1, mk_rsp(0, 0, 0, 0, 0)},
      '{mk_req(ACT_NONE_LAST, '1, '1, '1, '1, '1, '1), 1'b1, mk_rsp(0, 0, 0, 0, 0)},
      // extremes of the message fields
      '{mk_req(ACT_ENQ_NEW, 16'hffff, 16'hffff, 32'hffff_ffff, 0, 0, 0), 1'b1,
        mk_rsp(1, 0, 0, 0, 1)},
      '{mk_req(ACT_ENQ_OLD, 0, 0, 0, '1, '1, '1), 1'b1, mk_rsp(1, 0, 0, 0, 2)},
      '{mk_req(ACT_PUSH, 16'h1234, 16'h8000, 32'hdead_beef, 0, 0, 0), 1'b0, '0},
      '{mk_req(ACT_INS_AT, 16'h00a5, 16'h7000, 32'h5a5a_5a5a, 0, 0, 5'd3), 1'b0, '0},
      '{mk_req(ACT_INS_AT, 16'h0002, 16'h7000, 32'h0f0f_0f0f, 0, 0, 5'd31), 1'b0, '0},
      '{mk_req(ACT_INS_AT, 16'h0002, 16'h7000, 32'h1234_5678, 0, 0, 5'd0), 1'b0, '0},
      // reversed window takes the smallest, equal priorities go to the older one
      '{mk_req(ACT_REM_PRIO, 0, 0, 0, 16'h8000, 16'h7000, 0), 1'b0, '0},
      '{mk_req(ACT_REM_PRIO, 0, 0, 0, 16'h7000, 16'h7000, 0), 1'b0, '0},
      '{mk_req(ACT_REM_PRIO, 0, 0, 0, 16'h0001, 16'hfffe, 0), 1'b0, '0},
      '{mk_req(ACT_REM_KEY, 16'h5555, 0, 0, 0, 0, 0), 1'b0, '0},
      '{mk_req(ACT_REM_KEY, 16'h0000, 0, 0, 0, 0, 0), 1'b0, '0},
      '{mk_req(ACT_PUSH, 16'h0003, 16'h0010, 32'h0000_0001, 0, 0, 0), 1'b0, '0},
      '{mk_req(ACT_ENQ_OLD, 16'h0004, 16'h0020, 32'h8000_0000, 0, 0, 0), 1'b0, '0},
      // position zero behaves like the newest entry
      '{mk_req(ACT_REM_AT, 0, 0, 0, 0, 0, 5'd0), 1'b0, '0},
      '{mk_req(ACT_REM_AT, 0, 0, 0, 0, 0, 5'd31), 1'b0, '0},
      '{mk_req(ACT_DEQ, 0, 0, 0, 0, 0, 0), 1'b0, '0},
      '{mk_req(ACT_NONE_FIRST, 0, 0, 0, 0, 0, 0), 1'b0, '0},
      '{mk_req(ACT_POP, 0, 0, 0, 0, 0, 0), 1'b0, '0}
    };

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].rsp);

    for (int p = 0; p < NUM_PHASES; p++) begin
      settle_idle();
      // the first phase runs on the reset window
      if (p != 0) begin
        if (phases[p].first_bound < 0)
          set_window(16'($urandom()), 16'($urandom()));
        else
          set_window(16'(phases[p].first_bound), 16'(phases[p].second_bound));
      end
      sender_idle_pct = phases[p].idle_pct;
      rsp_idle_pct    = phases[p].idle_pct;
      repeat (phases[p].items)
        send_request(random_request(phases[p].insert_pct), 1'b0, '0);
    end

    settle_idle();
    if (mismatch_count == 0 && pending_rsp.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
